>>> design/hng_pkg.sv
// ============================================================================
// hng_pkg
// Shared types and constants for the heightmap normal generator.
// ============================================================================
package hng_pkg;

    // Default parameter values
    localparam int MAX_WIDTH_DEF        = 1023;
    localparam int HEIGHT_BITS_DEF      = 20;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int CNT_W  = 10;
    localparam int NORM_W = 16;

    // Fixed-point constants of the normal math
    localparam int FRAC_IN         = 8;
    localparam int SQRT_SHIFT      = 22;
    localparam int SIN_BASE_SHIFT  = 11;
    localparam int COS_BASE_SHIFT  = 2 * FRAC_IN + 3;

    localparam logic [CNT_W-1:0] GRID_WIDTH_RESET = 10'd64;
    localparam logic [CNT_W-1:0] ROW_MAX          = 10'd1023;

    // Control fields that travel down the pipeline with each word
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             last;
        logic             negx;
        logic             negy;
    } t_meta;

endpackage

>>> design/heightmap_normal_generator.sv
// ============================================================================
// heightmap_normal_generator
// Forward-difference normals of a height grid streamed in raster order.
// ============================================================================
// Usage:
//   Input words (i_height_sample, i_frame_start) move on i_valid with o_stall
//   low; each row carries grid_width+1 samples. i_frame_start restarts the
//   grid at column 0, row 0. Once a full row is buffered, every input word
//   produces one output word for the point directly above it: column, row,
//   height and the normal (x, y, z), fixed point with NORMAL_FRAC_BITS
//   fraction bits. The first row produces nothing.
//   Throughput: one word per cycle, sustained while the pipeline is not stalled.
//   Stages: the three front stages, the bit-per-stage square root over
//   2*HEIGHT_BITS+24 bits, the bit-per-stage dividers, one multiply stage
//   and the output register.
//   grid_width is written through i_grid_width_we / i_grid_width while no
//   word is in flight; it resets to 64.
//   Reset (synchronous, active low) empties the pipeline and clears the
//   position; line buffer contents are not cleared.
//   When i_stall is high with a word on the output, the whole pipeline
//   holds and o_stall rises in the same cycle.
// ============================================================================
module heightmap_normal_generator
    import hng_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int HEIGHT_BITS      = HEIGHT_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [HEIGHT_BITS-1:0] i_height_sample,
    input  logic                          i_frame_start,
    input  logic                          i_grid_width_we,
    input  logic [CNT_W-1:0]              i_grid_width,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [CNT_W-1:0]              o_column,
    output logic [CNT_W-1:0]              o_row,
    output logic signed [HEIGHT_BITS-1:0] o_point_height,
    output logic signed [NORM_W-1:0]      o_normal_x,
    output logic signed [NORM_W-1:0]      o_normal_y,
    output logic signed [NORM_W-1:0]      o_normal_z
);

    localparam int HB  = HEIGHT_BITS;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int SQW = 2 * HB + 1;
    localparam int QB  = (SQW + SQRT_SHIFT + 1) / 2;
    localparam int IW  = 2 * QB;
    localparam int QW  = F + 1;
    localparam int NW  = HB + 12 + F;
    localparam int PW  = 2 * QW;
    localparam int MW  = $bits(t_meta) + HB;
    localparam logic [PW:0]       HALF    = (PW+1)'(1) << (F - 1);
    localparam logic [NORM_W-1:0] NY_UNIT = (F >= 15) ? 16'h7FFF : NORM_W'(2 ** F);
    localparam logic [NW-1:0]     COS_NUM = NW'(1) << (COS_BASE_SHIFT + F);

    logic            en;
    t_meta           f_meta;
    logic [HB-1:0]   f_h0;
    logic [HB-1:0]   f_mx;
    logic [HB-1:0]   f_my;
    logic [SQW-1:0]  f_sqx;
    logic [SQW-1:0]  f_sqy;
    logic [QB-1:0]   qx;
    logic [QB-1:0]   qy;
    logic [HB-1:0]   d_mx;
    logic [HB-1:0]   d_my;
    logic [QW-1:0]   cx;
    logic [QW-1:0]   sx;
    logic [QW-1:0]   cy;
    logic [QW-1:0]   sy;
    logic [PW-1:0]   r_px;
    logic [PW-1:0]   r_py;
    logic [PW-1:0]   r_pz;
    t_meta           d_meta;
    logic [HB-1:0]   d_h0;
    logic            r_out_vld;

    // Round at bit F, apply sign, saturate to 16 bits
    function automatic logic [NORM_W-1:0] to_norm(input logic [PW-1:0] p, input logic neg);
        logic [PW:0] mag;
        begin
            mag = ((PW+1)'(p) + HALF) >> F;
            if (neg) begin
                to_norm = (mag > (PW+1)'(32768)) ? 16'h8000 : NORM_W'((PW+1)'(0) - mag);
            end else begin
                to_norm = (mag > (PW+1)'(32767)) ? 16'h7FFF : NORM_W'(mag);
            end
        end
    endfunction

    // Whole pipeline holds while the output word is stalled
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    hng_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_height_sample (i_height_sample),
        .i_frame_start   (i_frame_start),
        .i_grid_width_we (i_grid_width_we),
        .i_grid_width    (i_grid_width),
        .o_meta          (f_meta),
        .o_h0            (f_h0),
        .o_mx            (f_mx),
        .o_my            (f_my),
        .o_sqx           (f_sqx),
        .o_sqy           (f_sqy)
    );

    // Square roots of (1 + step^2) scaled by 2^19 (radicand shifted left by 22 bits)
    hng_sqrt_pipe #(.IW(IW)) u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (IW'({f_sqx, SQRT_SHIFT'(0)})),
        .o_root (qx)
    );

    hng_sqrt_pipe #(.IW(IW)) u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (IW'({f_sqy, SQRT_SHIFT'(0)})),
        .o_root (qy)
    );

    // Carry step magnitudes alongside the root
    hng_delay #(.W(2 * HB), .D(QB)) u_mag_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_data  ({f_mx, f_my}),
        .o_data  ({d_mx, d_my})
    );

    // Cosine and sine magnitudes
    hng_div_pipe #(.NW(NW), .DW(QB), .QW(QW)) u_div_cx (
        .i_clk (i_clk), .i_en (en), .i_num (COS_NUM), .i_den (qx), .o_quo (cx)
    );

    hng_div_pipe #(.NW(NW), .DW(QB), .QW(QW)) u_div_sx (
        .i_clk (i_clk), .i_en (en),
        .i_num (NW'(d_mx) << (SIN_BASE_SHIFT + F)), .i_den (qx), .o_quo (sx)
    );

    hng_div_pipe #(.NW(NW), .DW(QB), .QW(QW)) u_div_cy (
        .i_clk (i_clk), .i_en (en), .i_num (COS_NUM), .i_den (qy), .o_quo (cy)
    );

    hng_div_pipe #(.NW(NW), .DW(QB), .QW(QW)) u_div_sy (
        .i_clk (i_clk), .i_en (en),
        .i_num (NW'(d_my) << (SIN_BASE_SHIFT + F)), .i_den (qy), .o_quo (sy)
    );

    // Control fields and point height, aligned with the products
    hng_delay #(.W(MW), .D(QB + QW + 1)) u_meta_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_data  ({f_meta, f_h0}),
        .o_data  ({d_meta, d_h0})
    );

    // Component products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= PW'(sx) * PW'(cy);
            r_py <= PW'(cx) * PW'(cy);
            r_pz <= PW'(cx) * PW'(sy);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_meta.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_column       <= d_meta.col;
            o_row          <= d_meta.row;
            o_point_height <= d_h0;
            if (d_meta.last) begin
                o_normal_x <= '0;
                o_normal_y <= NY_UNIT;
                o_normal_z <= '0;
            end else begin
                o_normal_x <= to_norm(r_px, d_meta.negx);
                o_normal_y <= to_norm(r_py, 1'b0);
                o_normal_z <= to_norm(r_pz, d_meta.negy);
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule

>>> design/hng_delay.sv
// ============================================================================
// hng_delay
// Fixed-depth register delay line that advances on the pipeline enable.
// ============================================================================
module hng_delay
    import hng_pkg::*;
#(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data [D];

    // Shift one place per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) r_data[i] <= '0;
        end else if (i_en) begin
            r_data[0] <= i_data;
            for (int i = 1; i < D; i++) r_data[i] <= r_data[i-1];
        end
    end

    assign o_data = r_data[D-1];

endmodule

>>> design/hng_sqrt_pipe.sv
// ============================================================================
// hng_sqrt_pipe
// Pipelined integer square root, one result bit per stage (floor).
// ============================================================================
module hng_sqrt_pipe
    import hng_pkg::*;
#(
    parameter int IW = 64
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_val,
    output logic [IW/2-1:0] o_root
);

    localparam int RB = IW / 2;
    localparam int RW = RB + 2;
    localparam int TW = RW + 2;

    logic [RW-1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];
    logic [IW-1:0] r_val  [RB];

    for (genvar i = 0; i < RB; i++) begin : g_stage
        logic [RW-1:0] p_rem;
        logic [RB-1:0] p_root;
        logic [IW-1:0] p_val;
        logic [TW-1:0] t;
        logic [TW-1:0] trial;
        logic [RW-1:0] n_rem;
        logic [RB-1:0] n_root;

        if (i == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_val;
        end else begin : g_next
            assign p_rem  = r_rem[i-1];
            assign p_root = r_root[i-1];
            assign p_val  = r_val[i-1];
        end

        // Bring down two bits and try to subtract 4*root+1
        always_comb begin
            t     = {p_rem, p_val[IW-1 -: 2]};
            trial = TW'({p_root, 2'b01});
            if (t >= trial) begin
                n_rem  = RW'(t - trial);
                n_root = {p_root[RB-2:0], 1'b1};
            end else begin
                n_rem  = RW'(t);
                n_root = {p_root[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_root[i] <= n_root;
        end

        if (i < RB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= n_rem;
                    r_val[i] <= {p_val[IW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

>>> design/hng_div_pipe.sv
// ============================================================================
// hng_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit in QW bits.
// ============================================================================
module hng_div_pipe
    import hng_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int RW = DW + 1;

    logic [RW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [QW-1:0] r_quo  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [RW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [QW-1:0] p_bits;
        logic [QW-1:0] p_quo;
        logic [RW:0]   t;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (i == 0) begin : g_first
            assign p_rem  = RW'(i_num >> QW);
            assign p_den  = i_den;
            assign p_bits = i_num[QW-1:0];
            assign p_quo  = '0;
        end else begin : g_next
            assign p_rem  = r_rem[i-1];
            assign p_den  = r_den[i-1];
            assign p_bits = r_bits[i-1];
            assign p_quo  = r_quo[i-1];
        end

        // Shift in the next numerator bit and subtract the divisor if it fits
        always_comb begin
            t = {p_rem, p_bits[QW-1]};
            if (t >= (RW+1)'(p_den)) begin
                n_rem = RW'(t - (RW+1)'(p_den));
                n_quo = {p_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = RW'(t);
                n_quo = {p_quo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_quo[i] <= n_quo;
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i]  <= n_rem;
                    r_den[i]  <= p_den;
                    r_bits[i] <= {p_bits[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

>>> design/hng_front.sv
// ============================================================================
// hng_front
// Raster position tracking, line buffer and height steps: three register
// stages ending in 1 + the squared step magnitudes.
// ============================================================================
module hng_front
    import hng_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [HEIGHT_BITS-1:0] i_height_sample,
    input  logic                       i_frame_start,
    input  logic                       i_grid_width_we,
    input  logic [CNT_W-1:0]           i_grid_width,
    output t_meta                      o_meta,
    output logic [HEIGHT_BITS-1:0]     o_h0,
    output logic [HEIGHT_BITS-1:0]     o_mx,
    output logic [HEIGHT_BITS-1:0]     o_my,
    output logic [2*HEIGHT_BITS:0]     o_sqx,
    output logic [2*HEIGHT_BITS:0]     o_sqy
);

    localparam int HB    = HEIGHT_BITS;
    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SQW   = 2 * HB + 1;

    logic [CNT_W-1:0] r_gw;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic             r_primed;

    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] c_col;
    logic [CNT_W-1:0] c_row;
    logic             c_primed;
    logic             c_last;
    logic             accept;
    logic [AW-1:0]    a0;
    logic [AW-1:0]    a1;

    logic [HB-1:0]    r_mem [DEPTH];

    t_meta            r1_meta;
    logic [HB-1:0]    r1_h0;
    logic [HB-1:0]    r1_h1;
    logic [HB-1:0]    r1_samp;

    t_meta            r2_meta;
    logic [HB-1:0]    r2_h0;
    logic [HB-1:0]    r2_mx;
    logic [HB-1:0]    r2_my;
    logic [HB:0]      dx;
    logic [HB:0]      dy;

    t_meta            r3_meta;
    logic [HB-1:0]    r3_h0;
    logic [HB-1:0]    r3_mx;
    logic [HB-1:0]    r3_my;
    logic [SQW-1:0]   r3_sqx;
    logic [SQW-1:0]   r3_sqy;
    logic [2*HB-1:0]  px;
    logic [2*HB-1:0]  py;

    // Hold the grid width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_WIDTH_RESET;
        end else if (i_grid_width_we) begin
            r_gw <= i_grid_width;
        end
    end

    // Resolve the position of the incoming word
    assign w        = (32'(r_gw) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : r_gw;
    assign c_col    = i_frame_start ? '0 : r_col;
    assign c_row    = i_frame_start ? '0 : r_row;
    assign c_primed = i_frame_start ? 1'b0 : r_primed;
    assign c_last   = (c_col >= w);
    assign accept   = i_valid && i_en;
    assign a0       = AW'(c_col);
    assign a1       = AW'({1'b0, c_col} + (CNT_W+1)'(1));

    // Advance column and row counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_primed <= 1'b0;
        end else if (accept) begin
            r_row    <= c_row;
            r_primed <= c_primed;
            if (c_last) begin
                r_col <= '0;
                if (!c_primed) begin
                    r_primed <= 1'b1;
                end else if (c_row != ROW_MAX) begin
                    r_row <= c_row + CNT_W'(1);
                end
            end else begin
                r_col <= c_col + CNT_W'(1);
            end
        end
    end

    // Line buffer: read the point and its right neighbor, then replace the point
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_h0 <= r_mem[a0];
            r1_h1 <= r_mem[a1];
            if (accept) r_mem[a0] <= i_height_sample;
        end
    end

    // Stage 1: position and the new sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_meta.vld <= 1'b0;
        end else if (i_en) begin
            r1_meta.vld <= accept && c_primed;
        end
        if (i_en) begin
            r1_meta.col  <= c_col;
            r1_meta.row  <= c_row;
            r1_meta.last <= c_last;
            r1_meta.negx <= 1'b0;
            r1_meta.negy <= 1'b0;
            r1_samp      <= i_height_sample;
        end
    end

    // Stage 2: height steps, their signs and magnitudes
    assign dx = {r1_h1[HB-1], r1_h1} - {r1_h0[HB-1], r1_h0};
    assign dy = {r1_samp[HB-1], r1_samp} - {r1_h0[HB-1], r1_h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta.vld <= 1'b0;
        end else if (i_en) begin
            r2_meta.vld <= r1_meta.vld;
        end
        if (i_en) begin
            r2_meta.col  <= r1_meta.col;
            r2_meta.row  <= r1_meta.row;
            r2_meta.last <= r1_meta.last;
            r2_meta.negx <= !dx[HB] && (dx != '0);
            r2_meta.negy <= !dy[HB] && (dy != '0);
            r2_h0        <= r1_h0;
            r2_mx        <= HB'(dx[HB] ? ((HB+1)'(0) - dx) : dx);
            r2_my        <= HB'(dy[HB] ? ((HB+1)'(0) - dy) : dy);
        end
    end

    // Stage 3: 1 + step^2 in input units
    assign px = (2*HB)'(r2_mx) * (2*HB)'(r2_mx);
    assign py = (2*HB)'(r2_my) * (2*HB)'(r2_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_meta.vld <= 1'b0;
        end else if (i_en) begin
            r3_meta.vld <= r2_meta.vld;
        end
        if (i_en) begin
            r3_meta.col  <= r2_meta.col;
            r3_meta.row  <= r2_meta.row;
            r3_meta.last <= r2_meta.last;
            r3_meta.negx <= r2_meta.negx;
            r3_meta.negy <= r2_meta.negy;
            r3_h0        <= r2_h0;
            r3_mx        <= r2_mx;
            r3_my        <= r2_my;
            r3_sqx       <= SQW'(px) + (SQW'(1) << (2 * FRAC_IN));
            r3_sqy       <= SQW'(py) + (SQW'(1) << (2 * FRAC_IN));
        end
    end

    assign o_meta = r3_meta;
    assign o_h0   = r3_h0;
    assign o_mx   = r3_mx;
    assign o_my   = r3_my;
    assign o_sqx  = r3_sqx;
    assign o_sqy  = r3_sqy;

endmodule

>>> design/hng_checker.sv
// ============================================================================
// hng_checker
// Port-level checks of the heightmap normal generator, bound to the top.
// ============================================================================
module hng_checker
    import hng_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     o_stall,
    input logic                     i_stall,
    input logic [CNT_W-1:0]         o_column,
    input logic [CNT_W-1:0]         o_row,
    input logic signed [NORM_W-1:0] o_normal_x,
    input logic signed [NORM_W-1:0] o_normal_y,
    input logic signed [NORM_W-1:0] o_normal_z
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word after reset");

    // Input side stalls exactly when the output word is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output backpressure");

    // A stalled output word holds its column, row, normal x and normal z
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_column) && $stable(o_row)
            && $stable(o_normal_x) && $stable(o_normal_z))
        else $error("stalled output word changed");

    // The up component is never negative
    a_ny_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_normal_y[NORM_W-1])
        else $error("negative normal y");

endmodule

bind heightmap_normal_generator hng_checker u_hng_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .o_stall    (o_stall),
    .i_stall    (i_stall),
    .o_column   (o_column),
    .o_row      (o_row),
    .o_normal_x (o_normal_x),
    .o_normal_y (o_normal_y),
    .o_normal_z (o_normal_z)
);
